@@ design/fwsp_pkg.sv @@
// Shared types and constants for the fixed-width symbol packer.
`default_nettype none
package fwsp_pkg;

  localparam int SYM_W           = 8;
  localparam int CODE_W          = 8;
  localparam int BYTE_W          = 8;
  localparam int CW_W            = 4;
  localparam int PAD_W           = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 4;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [CW_W-1:0]  CW_RESET  = CW_W'(8);
  localparam logic [PAD_W-1:0] PAD_RESET = '0;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_WIDTH = 1'b0,
    CFG_PAD_BITS   = 1'b1
  } cfg_idx_e;

  // Encode item after table lookup.
  typedef struct packed {
    logic              vld;
    logic              last;
    logic              hit;
    logic [CODE_W-1:0] code;
  } lkp_t;

  // One or two packed bytes caused by a single encode item.
  typedef struct packed {
    logic              two;
    logic [BYTE_W-1:0] b0;
    logic              fin0;
    logic [BYTE_W-1:0] b1;
    logic              miss;
  } grp_t;

endpackage
`default_nettype wire

@@ design/fwsp_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module fwsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

@@ design/fwsp_table.sv @@
// Symbol-to-code table: valid bits, code RAM and lookup stage register.
`default_nettype none
module fwsp_table #(
  parameter int TABLE_DEPTH = fwsp_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        acc_i,
  input  wire logic                        op_i,
  input  wire logic [fwsp_pkg::SYM_W-1:0]  sym_i,
  input  wire logic [fwsp_pkg::CODE_W-1:0] code_i,
  input  wire logic                        last_i,
  output fwsp_pkg::lkp_t                   lkp_o
);
  import fwsp_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [TABLE_DEPTH-1:0] vld_q;
  logic [AW-1:0]          idx;
  logic                   in_range;
  logic                   wr;
  logic                   s1_vld_q;
  logic                   s1_last_q;
  logic                   s1_hit_q;
  logic [CODE_W-1:0]      rdata;

  assign idx      = sym_i[AW-1:0];
  assign in_range = {1'b0, sym_i} < (SYM_W+1)'(TABLE_DEPTH);
  assign wr       = acc_i && (op_e'(op_i) == OP_LOAD) && in_range;

  fwsp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .addr_i  (idx),
    .wdata_i (code_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      if (wr) begin
        vld_q[idx] <= 1'b1;
      end
      s1_vld_q <= acc_i && (op_e'(op_i) == OP_ENCODE);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= last_i;
    s1_hit_q  <= in_range && vld_q[idx];
  end

  assign lkp_o.vld  = s1_vld_q;
  assign lkp_o.last = s1_last_q;
  assign lkp_o.hit  = s1_hit_q;
  assign lkp_o.code = rdata;

endmodule
`default_nettype wire

@@ design/fwsp_packer.sv @@
// Bit accumulator: appends one code per item and forms output bytes.
`default_nettype none
module fwsp_packer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [fwsp_pkg::CW_W-1:0]  code_width_i,
  input  wire logic [fwsp_pkg::PAD_W-1:0] pad_bits_i,
  input  wire fwsp_pkg::lkp_t             lkp_i,
  output logic                            push_o,
  output fwsp_pkg::grp_t                  grp_o
);
  import fwsp_pkg::*;

  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [2:0]        pend_q, pend_d;
  logic              started_q, started_d;
  logic              miss_q, miss_d;

  logic [CW_W-1:0]     w;
  logic [BYTE_W-1:0]   cmask;
  logic [BYTE_W-1:0]   code_m;
  logic [BYTE_W-1:0]   acc_in;
  logic [2:0]          n_in;
  logic [2*BYTE_W-1:0] acc16;
  logic [3:0]          n;
  logic                full;
  logic [2:0]          nrem;
  logic [BYTE_W-1:0]   byte0;
  logic [BYTE_W-1:0]   acc_rem;
  logic [BYTE_W-1:0]   flush_b;
  logic                flush;

  always_comb begin
    if (code_width_i == '0) begin
      w = CW_W'(1);
    end else if (code_width_i > CW_W'(8)) begin
      w = CW_W'(8);
    end else begin
      w = code_width_i;
    end
    cmask   = 8'hFF >> (4'd8 - w);
    code_m  = lkp_i.hit ? (lkp_i.code & cmask) : '0;
    acc_in  = started_q ? acc_q : '0;
    n_in    = started_q ? pend_q : pad_bits_i;
    acc16   = ({8'h00, acc_in} << w) | {8'h00, code_m};
    n       = {1'b0, n_in} + w;
    full    = n[3];
    nrem    = n[2:0];
    byte0   = 8'(acc16 >> nrem);
    acc_rem = acc16[7:0] & ~(8'hFF << nrem);
    flush_b = 8'({8'h00, acc_rem} << (4'd8 - {1'b0, nrem}));
    flush   = lkp_i.last && (nrem != 3'd0);

    miss_d    = miss_q || (lkp_i.vld && !lkp_i.hit);
    acc_d     = acc_q;
    pend_d    = pend_q;
    started_d = started_q;
    if (lkp_i.vld) begin
      if (lkp_i.last) begin
        acc_d     = '0;
        pend_d    = '0;
        started_d = 1'b0;
      end else begin
        acc_d     = acc_rem;
        pend_d    = nrem;
        started_d = 1'b1;
      end
    end

    push_o     = lkp_i.vld && (full || flush);
    grp_o.two  = full && flush;
    grp_o.b0   = full ? byte0 : flush_b;
    grp_o.fin0 = full ? (lkp_i.last && (nrem == 3'd0)) : 1'b1;
    grp_o.b1   = flush_b;
    grp_o.miss = miss_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      pend_q    <= '0;
      started_q <= 1'b0;
      miss_q    <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      pend_q    <= pend_d;
      started_q <= started_d;
      miss_q    <= miss_d;
    end
  end

endmodule
`default_nettype wire

@@ design/fwsp_queue.sv @@
// Output queue of byte groups, drained one byte per handshake.
`default_nettype none
module fwsp_queue (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire fwsp_pkg::grp_t              grp_i,
  input  wire logic                        inflight_i,
  output logic                             room_o,
  output logic                             m_tvalid_o,
  input  wire logic                        m_tready_i,
  output logic [fwsp_pkg::BYTE_W-1:0]      m_tdata_o,
  output logic                             m_tlast_o,
  output logic                             m_tuser_o
);
  import fwsp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  grp_t          ent_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          half_q;
  grp_t          head;
  logic          hs;
  logic          pop;

  assign head       = ent_q[rd_q];
  assign m_tvalid_o = cnt_q != '0;
  assign m_tdata_o  = half_q ? head.b1 : head.b0;
  assign m_tlast_o  = half_q ? 1'b1 : head.fin0;
  assign m_tuser_o  = head.miss;
  assign hs         = m_tvalid_o && m_tready_i;
  assign pop        = hs && (!head.two || half_q);
  assign room_o     = ((CW+1)'(cnt_q) + (CW+1)'(inflight_i)) < (CW+1)'(QUEUE_DEPTH);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      half_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + PW'(1);
      end
      if (hs) begin
        half_q <= !pop;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= grp_i;
    end
  end

endmodule
`default_nettype wire

@@ design/fixed_width_symbol_packer.sv @@
// Top level of the fixed-width symbol packer.
//
//  Channel   Dir  Signals                         Contents
//  s_axis    in   tvalid tready tdata tuser tlast op, symbol, code, last
//  m_axis    out  tvalid tready tdata tuser tlast out_byte, unknown_seen, last_byte
//  cfg       in   cfg_we_i cfg_idx_i cfg_data_i   code_width (0), pad_bits (1)
//
// One input item per cycle while the queue has room; an item reaches the output queue
// in the cycle after acceptance (table RAM read, then accumulator update). An item
// yields zero, one or two bytes; the output side drains at most one byte per cycle,
// so items that yield two bytes hold the input back through the four-group queue.
// Reset marks every table entry invalid at once and starts a new stream.
`default_nettype none
module fixed_width_symbol_packer #(
  parameter int TABLE_DEPTH = fwsp_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [15:0]                     s_axis_tdata,  // symbol[7:0], code[15:8]
  input  wire logic                            s_axis_tuser,  // op
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [fwsp_pkg::BYTE_W-1:0]          m_axis_tdata,  // out_byte[7:0]
  output logic                                 m_axis_tuser,  // unknown_seen
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_we_i,
  input  wire logic [fwsp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fwsp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fwsp_pkg::*;

  logic [CW_W-1:0]  code_width_q;
  logic [PAD_W-1:0] pad_bits_q;
  logic             acc;
  lkp_t             lkp;
  grp_t             grp;
  logic             push;
  logic             room;

  assign acc           = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_width_q <= CW_RESET;
      pad_bits_q   <= PAD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CODE_WIDTH: code_width_q <= cfg_data_i[CW_W-1:0];
        CFG_PAD_BITS:   pad_bits_q   <= cfg_data_i[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  fwsp_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .op_i   (s_axis_tuser),
    .sym_i  (s_axis_tdata[SYM_W-1:0]),
    .code_i (s_axis_tdata[SYM_W+CODE_W-1:SYM_W]),
    .last_i (s_axis_tlast),
    .lkp_o  (lkp)
  );

  fwsp_packer u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_width_i (code_width_q),
    .pad_bits_i   (pad_bits_q),
    .lkp_i        (lkp),
    .push_o       (push),
    .grp_o        (grp)
  );

  fwsp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .grp_i      (grp),
    .inflight_i (lkp.vld),
    .room_o     (room),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser)
  );

`ifndef SYNTH
  a_encode_looks_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (op_e'(s_axis_tuser) == OP_ENCODE) |=> lkp.vld)
    else $error("encode item did not reach lookup stage");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (op_e'(s_axis_tuser) == OP_LOAD) |=> !lkp.vld)
    else $error("table load produced a lookup");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && grp.two |-> !grp.fin0 && lkp.last)
    else $error("two-byte group with misplaced final byte");

  a_push_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> $past(acc))
    else $error("output group without an accepted item");
`endif

endmodule
`default_nettype wire
